[sv/chs_pkg.sv]
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the CHS transfer segmenter.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int MAX_REQUEST_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 2'd3;

  typedef struct packed {
    logic               op;
    logic [COUNT_W-1:0] sector_count;
  } request_t;

  typedef struct packed {
    logic       command;
    logic [7:0] drive_id;
    logic [7:0] head_index;
    logic [9:0] cylinder_index;
    logic [5:0] start_sector;
    logic [5:0] segment_length;
    logic       last;
    logic       short_transfer;
  } result_t;

  typedef struct packed {
    logic               op;
    logic [COUNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic [5:0] sector;
    logic [9:0] cylinder;
    logic [8:0] head;
  } addr_t;

endpackage

[sv/chs_fifo.sv]
// ----------------------------------------------------------------------------
// chs_fifo
// Small synchronous queue with registered storage and a fill count.
// ----------------------------------------------------------------------------
module chs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[sv/chs_front.sv]
// ----------------------------------------------------------------------------
// chs_front
// Request intake: saturate the sector count and drop empty requests.
// ----------------------------------------------------------------------------
module chs_front import chs_pkg::*; #(
  parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
  input  logic     push,
  input  request_t request,
  output logic     full,
  input  logic     job_full,
  output logic     job_push,
  output job_t     job
);

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_REQUEST);

  assign full     = job_full;
  assign job_push = push & ~job_full & (request.sector_count != '0);
  assign job.op   = request.op;
  assign job.count = (request.sector_count > MAX_CNT) ? MAX_CNT : request.sector_count;

endmodule

[sv/chs_back.sv]
// ----------------------------------------------------------------------------
// chs_back
// Segment engine: holds geometry and address; a track run a cycle unless held.
// ----------------------------------------------------------------------------
module chs_back import chs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  job_empty,
  input  job_t                  job,
  output logic                  job_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output result_t               res
);

  logic [5:0]         spt;
  logic [10:0]        cyl_cnt;
  logic [8:0]         head_cnt;
  logic [7:0]         drive;
  logic [5:0]         spt_eff;
  logic [10:0]        cyl_eff;
  logic [8:0]         heads_eff;
  addr_t              cur;
  addr_t              cur_next;
  addr_t              fixed;
  addr_t              moved;
  addr_t              advanced;
  logic               fix_pending;
  logic               busy;
  logic               busy_next;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] rem_next;
  logic               op;
  logic               op_sel;
  logic [COUNT_W-1:0] rem_sel;
  logic               start;
  logic               step;
  logic               at_end;
  logic [5:0]         room;
  logic [5:0]         len;
  logic [COUNT_W-1:0] left;
  logic               media_end;
  logic               done;

  function automatic addr_t carry_addr(addr_t a, logic [5:0] s, logic [10:0] c,
                                       logic [8:0] h);
    addr_t       r;
    logic [10:0] cyl_inc;
    r       = a;
    cyl_inc = {1'b0, a.cylinder};
    if (a.sector >= s) begin
      r.sector = '0;
      cyl_inc  = cyl_inc + 11'd1;
    end
    if (cyl_inc >= c) begin
      r.cylinder = '0;
      if (a.head < h) begin
        r.head = a.head + 9'd1;
      end
    end else begin
      r.cylinder = cyl_inc[9:0];
    end
    return r;
  endfunction

  assign spt_eff   = (spt == '0) ? 6'd1 : spt;
  assign cyl_eff   = (cyl_cnt == '0) ? 11'd1 : ((cyl_cnt > 11'd1024) ? 11'd1024 : cyl_cnt);
  assign heads_eff = (head_cnt > 9'd256) ? 9'd256 : head_cnt;

  assign fixed = carry_addr(cur, spt_eff, cyl_eff, heads_eff);

  assign start   = ~busy & ~fix_pending & ~job_empty;
  assign step    = (busy | start) & ~res_full;
  assign op_sel  = busy ? op : job.op;
  assign rem_sel = busy ? rem : job.count;
  assign at_end  = ~busy & (cur.head >= heads_eff);

  assign room = spt_eff - cur.sector;
  assign len  = (rem_sel < {1'b0, room}) ? rem_sel[5:0] : room;
  assign left = rem_sel - {1'b0, len};

  always_comb begin
    moved        = cur;
    moved.sector = cur.sector + len;
  end

  assign advanced  = carry_addr(moved, spt_eff, cyl_eff, heads_eff);
  assign media_end = (advanced.head >= heads_eff);
  assign done      = (left == '0) | media_end;

  assign job_pop  = start & step;
  assign res_push = step;

  always_comb begin
    res.command        = op_sel;
    res.drive_id       = drive;
    res.head_index     = cur.head[7:0];
    res.cylinder_index = cur.cylinder;
    res.start_sector   = cur.sector + 6'd1;
    if (at_end) begin
      res.segment_length = '0;
      res.last           = 1'b1;
      res.short_transfer = 1'b1;
    end else begin
      res.segment_length = len;
      res.last           = done;
      res.short_transfer = done & (left != '0);
    end
  end

  always_comb begin
    cur_next  = cur;
    busy_next = busy;
    rem_next  = rem;
    if (~busy & fix_pending & ~job_empty) begin
      cur_next = fixed;
    end else if (step && !at_end) begin
      cur_next  = advanced;
      busy_next = ~done;
      rem_next  = left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spt         <= 6'd18;
      cyl_cnt     <= 11'd80;
      head_cnt    <= 9'd2;
      drive       <= 8'd0;
      cur         <= '0;
      busy        <= 1'b0;
      rem         <= '0;
      op          <= 1'b0;
      fix_pending <= 1'b0;
    end else begin
      cur  <= cur_next;
      busy <= busy_next;
      rem  <= rem_next;
      if (step) begin
        op <= op_sel;
      end
      if (cfg_valid) begin
        fix_pending <= 1'b1;
        unique case (cfg_index)
          CFG_SPT:   spt      <= cfg_data[5:0];
          CFG_CYLS:  cyl_cnt  <= cfg_data[10:0];
          CFG_HEADS: head_cnt <= cfg_data[8:0];
          CFG_DRIVE: drive    <= cfg_data[7:0];
          default:   ;
        endcase
      end else if (!busy && !job_empty) begin
        fix_pending <= 1'b0;
      end
    end
  end

endmodule

[sv/chs_transfer_segmenter_core.sv]
// ----------------------------------------------------------------------------
// chs_transfer_segmenter_core
// Splits sector transfer requests into track runs at a CHS disk address.
// ----------------------------------------------------------------------------
// Requests enter through push/full with an op and a sector count; a count of
// zero is taken and dropped, a count above MAX_REQUEST is saturated. Results
// leave through empty/pop, one per track run, oldest first, each carrying
// drive, head, cylinder, one-based start sector, length and last/short flags.
// Geometry and drive number are written on the cfg_valid/cfg_ready channel,
// which is always ready; write it only while the block is idle.
// The first result of a request passes through the request queue and the
// result queue before it reaches the result ports; the first request after
// a geometry write also waits while the address is carried. The segment
// engine emits one run per cycle while the result queue has room (a single
// run at end of media) and starts each request after the previous one ends.
// A request queue decouples intake from the engine, and a result queue lets
// the engine keep working while results wait; when the receiver stalls the
// engine halts once the result queue fills, then the request queue fills and
// full rises. Reset restores default geometry and address zero and empties
// both queues.
// ----------------------------------------------------------------------------
module chs_transfer_segmenter_core import chs_pkg::*; #(
  parameter int MAX_REQUEST = MAX_REQUEST_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  request_t              request,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int JOB_W = $bits(job_t);
  localparam int RES_W = $bits(result_t);

  logic             job_full;
  logic             job_push;
  logic             job_empty;
  logic             job_pop;
  job_t             job_in;
  job_t             job_out;
  logic [JOB_W-1:0] job_wdata;
  logic [JOB_W-1:0] job_rdata;
  logic             res_full;
  logic             res_push;
  result_t          res_in;
  logic [RES_W-1:0] res_wdata;
  logic [RES_W-1:0] res_rdata;

  assign cfg_ready = 1'b1;
  assign job_wdata = job_in;
  assign job_out   = job_rdata;
  assign res_wdata = res_in;
  assign result    = res_rdata;

  chs_front #(
    .MAX_REQUEST(MAX_REQUEST)
  ) u_front (
    .push     (push),
    .request  (request),
    .full     (full),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  chs_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_wdata),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  chs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  chs_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

endmodule

[test/chs_transfer_segmenter_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chs_transfer_segmenter_core_tb
// Self-checking bench for the CHS transfer segmenter.
// ----------------------------------------------------------------------------
// Transfer requests go in on the push/full side. A scoreboard keeps its own
// disk geometry and current address, and splits each accepted request into
// expected track runs. Every run popped from the block is checked field by
// field against the oldest expected run.
// A directed part covers count extremes, zero and saturated counts, end of
// media, short transfers, an address carried past a shrunken geometry and
// head wrap of the head index. Random parts follow under several geometries
// with three idling patterns, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module chs_transfer_segmenter_core_tb;
  import chs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  class segment_scoreboard;
    logic [5:0]  spt;
    logic [10:0] cyls;
    logic [8:0]  heads;
    logic [7:0]  drive;
    int unsigned sector;
    int unsigned cylinder;
    int unsigned head;
    result_t     runs_due[$];
    int          errors;

    function new();
      spt = 6'd18;
      cyls = 11'd80;
      heads = 9'd2;
      drive = 8'd0;
      sector = 0;
      cylinder = 0;
      head = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SPT: spt = data[5:0];
        CFG_CYLS: cyls = data;
        CFG_HEADS: heads = data[8:0];
        CFG_DRIVE: drive = data[7:0];
        default: ;
      endcase
    endfunction

    function void carry(int unsigned spt_e, int unsigned cyl_e, int unsigned head_e);
      if (sector >= spt_e) begin
        sector = 0;
        cylinder++;
      end
      if (cylinder >= cyl_e) begin
        cylinder = 0;
        if (head < head_e) head++;
      end
    endfunction

    function result_t run_at(logic op, int unsigned len);
      result_t r;
      r.command = op;
      r.drive_id = drive;
      r.head_index = 8'(head);
      r.cylinder_index = 10'(cylinder);
      r.start_sector = 6'(sector + 1);
      r.segment_length = 6'(len);
      r.last = 1'b0;
      r.short_transfer = 1'b0;
      return r;
    endfunction

    function void take_request(request_t req);
      int unsigned left;
      int unsigned room;
      int unsigned len;
      int unsigned spt_e;
      int unsigned cyl_e;
      int unsigned head_e;
      result_t r;
      left = req.sector_count;
      if (left > MAX_REQUEST_DEF) left = MAX_REQUEST_DEF;
      if (left == 0) return;
      spt_e = (spt == 0) ? 1 : spt;
      cyl_e = (cyls == 0) ? 1 : (cyls > 1024) ? 1024 : cyls;
      head_e = (heads > 256) ? 256 : heads;
      carry(spt_e, cyl_e, head_e);
      if (head >= head_e) begin
        r = run_at(req.op, 0);
        r.last = 1'b1;
        r.short_transfer = 1'b1;
        runs_due.push_back(r);
        return;
      end
      while (left > 0) begin
        room = spt_e - sector;
        len = (left < room) ? left : room;
        r = run_at(req.op, len);
        left -= len;
        sector += len;
        carry(spt_e, cyl_e, head_e);
        if (left == 0 || head >= head_e) begin
          r.last = 1'b1;
          r.short_transfer = (left > 0);
        end
        runs_due.push_back(r);
        if (r.last) break;
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10) $display("mismatch %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_run(result_t got);
      result_t want;
      if (runs_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected run: got %h", got);
        return;
      end
      want = runs_due.pop_front();
      compare("command", want.command, got.command);
      compare("drive_id", want.drive_id, got.drive_id);
      compare("head_index", want.head_index, got.head_index);
      compare("cylinder_index", want.cylinder_index, got.cylinder_index);
      compare("start_sector", want.start_sector, got.start_sector);
      compare("segment_length", want.segment_length, got.segment_length);
      compare("last", want.last, got.last);
      compare("short_transfer", want.short_transfer, got.short_transfer);
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  request_t              request = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SPT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                send_idle = 0;
  int                recv_idle = 0;
  bit                holding = 1'b0;
  event              hold_off;
  int unsigned       cycles = 0;
  segment_scoreboard board = new();

  chs_transfer_segmenter_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .request(request),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    pop <= !holding && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    forever begin
      @(hold_off);
      holding = 1'b1;
      repeat (400) @(posedge clk);
      holding = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check_run(result);
  end

  task automatic send_request(logic kind, logic [COUNT_W-1:0] count);
    request_t req;
    req.op = kind;
    req.sector_count = count;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    request <= req;
    do @(posedge clk); while (full);
    board.take_request(req);
  endtask

  // hold until every expected run is out, then let the engine drain
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (board.runs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  task automatic set_geometry(logic [CFG_DATA_W-1:0] spt, logic [CFG_DATA_W-1:0] cyls,
                              logic [CFG_DATA_W-1:0] heads, logic [CFG_DATA_W-1:0] drv);
    settle();
    write_reg(CFG_SPT, spt);
    write_reg(CFG_CYLS, cyls);
    write_reg(CFG_HEADS, heads);
    write_reg(CFG_DRIVE, drv);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_requests(int n);
    int sent;
    logic [COUNT_W-1:0] count;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(9))
        0: count = '0;
        1: count = COUNT_W'($urandom_range(127, 65));
        2, 3, 4, 5: count = COUNT_W'($urandom_range(8, 1));
        default: count = COUNT_W'($urandom_range(64, 1));
      endcase
      send_request(1'($urandom_range(1)), count);
      sent++;
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] spt;
    logic [CFG_DATA_W-1:0] cyls;
    logic [CFG_DATA_W-1:0] heads;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    send_idle = 27;
    recv_idle = 56;
    send_request(1'b0, 7'd1);
    send_request(1'b1, 7'd64);
    send_request(1'b0, 7'd0);
    send_request(1'b1, 7'd127);
    send_request(1'b0, 7'd65);
    send_request(1'b1, 7'd17);
    send_request(1'b0, 7'd18);
    send_request(1'b1, 7'd36);
    send_request(1'b0, 7'd2);

    // no heads at all: always at end of media
    set_geometry(11'd63, 11'd1024, 11'd0, 11'd255);
    send_request(1'b1, 7'd5);
    send_request(1'b0, 7'd127);

    // zero geometry; address carried into the head, then a short transfer
    set_geometry(11'd0, 11'd0, 11'd3, 11'h05A);
    send_request(1'b0, 7'd64);
    send_request(1'b1, 7'd1);

    for (int k = 0; k < 6; k++) begin
      send_idle = (k < 2) ? 27 : (k < 4) ? 56 : 0;
      recv_idle = (k < 2) ? 56 : (k < 4) ? 27 : 0;
      spt = (k == 0) ? 11'd63 : (k == 1) ? 11'd1 : CFG_DATA_W'($urandom_range(63, 1));
      cyls = (k == 0) ? 11'd1024 : (k == 1) ? 11'd2047 : CFG_DATA_W'($urandom_range(2047, 64));
      heads = (k == 1) ? 11'd511 : (k == 0) ? 11'd256 : CFG_DATA_W'($urandom_range(511, 256));
      set_geometry(spt, cyls, heads, CFG_DATA_W'($urandom_range(255)));
      if (k == 5) -> hold_off;
      random_requests(60);
    end

    // run the head up to its limit so the head index wraps
    set_geometry(11'd0, 11'd0, 11'd300, 11'h0A5);
    while (board.head < 256) send_request(1'($urandom_range(1)), 7'd64);
    send_request(1'b1, 7'd3);
    send_request(1'b0, 7'd0);

    @(negedge clk);
    push <= 1'b0;
    while (board.runs_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.runs_due.size() != 0) begin
      $display("%0d expected runs never arrived", board.runs_due.size());
      board.errors += board.runs_due.size();
    end
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/chs_pkg.sv
sv/chs_fifo.sv
sv/chs_front.sv
sv/chs_back.sv
sv/chs_transfer_segmenter_core.sv
test/chs_transfer_segmenter_core_tb.sv
